// ===== rtl/sdspi_pkg.sv =====
// Package for the SD-card SPI-mode block transaction sequencer.
// Phase, job and status codes, the job descriptor and frame helpers.
// No dependencies.
package sdspi_pkg;

  // input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_RX    = 2'd1;
  localparam logic [1:0] FUNC_WR    = 2'd2;

  // start operations
  localparam logic [1:0] OP_BLK_RD = 2'd0;
  localparam logic [1:0] OP_BLK_WR = 2'd1;
  localparam logic [1:0] OP_REG_RD = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_RESP_ATTEMPTS  = 2'd0;
  localparam logic [1:0] CFG_TRANS_ATTEMPTS = 2'd1;
  localparam logic [1:0] CFG_BLOCK_LEN      = 2'd2;

  localparam logic [15:0] RESP_ATTEMPTS_RST  = 16'd8;
  localparam logic [15:0] TRANS_ATTEMPTS_RST = 16'd1000;
  localparam logic [11:0] BLOCK_LEN_RST      = 12'd512;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_R1   = 3'd1;
  localparam logic [2:0] ST_ERR_TOK  = 3'd2;
  localparam logic [2:0] ST_NO_TOKEN = 3'd3;
  localparam logic [2:0] ST_WR_REJ   = 3'd4;
  localparam logic [2:0] ST_NO_DRESP = 3'd5;

  // command numbers and bytes on the wire
  localparam logic [5:0] CMD_READ_BLOCK  = 6'd17;
  localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;
  localparam logic [7:0] BYTE_IDLE       = 8'hFF;
  localparam logic [7:0] BYTE_CMD_BASE   = 8'h40;
  localparam logic [7:0] BYTE_CRC        = 8'h95;
  localparam logic [7:0] TOKEN_START     = 8'hFE;
  localparam logic [7:0] DRESP_MASK      = 8'h11;
  localparam logic [7:0] DRESP_MARK      = 8'h01;
  localparam logic [2:0] DRESP_ACCEPTED  = 3'd2;
  localparam logic [7:0] ERR_TOKEN_MAX   = 8'd8;
  localparam logic [15:0] CRC_BYTES      = 16'd2;

  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned RETRY_LEN = FRAME_LEN + 1;
  localparam int unsigned BEAT_W    = $clog2(RETRY_LEN);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_R1,
    PH_TOKEN,
    PH_RDATA,
    PH_CRC,
    PH_WDATA,
    PH_DRESP
  } phase_e;

  typedef enum logic [1:0] {
    JOB_SINGLE,  // one result described in full by the job
    JOB_FRAME,   // eight command frame bytes
    JOB_RETRY    // chip select release, then eight frame bytes
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cs_active;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        done_res;
    logic [2:0]  status;
  } job_t;

  // limit of zero behaves as one
  function automatic logic reached(logic [15:0] cnt, logic [15:0] lim);
    logic [15:0] lim_eff;
    lim_eff = (lim == 16'd0) ? 16'd1 : lim;
    return cnt >= lim_eff;
  endfunction

  function automatic logic [7:0] frame_byte(logic [2:0] idx, logic [5:0] cmd,
                                            logic [31:0] arg);
    logic [7:0] b;
    case (idx)
      3'd0:    b = BYTE_IDLE;
      3'd1:    b = BYTE_CMD_BASE | {2'b00, cmd};
      3'd2:    b = arg[31:24];
      3'd3:    b = arg[23:16];
      3'd4:    b = arg[15:8];
      3'd5:    b = arg[7:0];
      3'd6:    b = BYTE_CRC;
      default: b = BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/sdspi_if.sv =====
// Request channel interfaces of the SD-card SPI-mode sequencer.
// Valid/ready handshake with the payload fields. No dependencies.
interface sdspi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  op;
  logic [5:0]  cmd_index;
  logic [31:0] argument;
  logic [11:0] reg_len;
  logic [7:0]  rx_byte;
  logic [7:0]  wr_byte;

  modport source (output valid, func, op, cmd_index, argument, reg_len, rx_byte,
                  wr_byte, input ready);
  modport sink (input valid, func, op, cmd_index, argument, reg_len, rx_byte,
                wr_byte, output ready);
endinterface

interface sdspi_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       cs_active;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       done_res;
  logic [2:0] status;
  logic       last;

  modport source (output valid, tx_valid, tx_byte, cs_active, data_valid, data_byte,
                  done_res, status, last, input ready);
  modport sink (input valid, tx_valid, tx_byte, cs_active, data_valid, data_byte,
                done_res, status, last, output ready);
endinterface

// ===== rtl/sd_spi_block_transaction.sv =====
// Top level of the SD-card SPI-mode block transaction sequencer.
// Front end, job queue and back end. Uses sdspi_pkg, sdspi_if.
//
//   channel  dir  handshake          carries
//   in_ch    in   valid/ready        func, op, cmd_index, argument, reg_len, rx/wr byte
//   out_ch   out  valid/ready        tx, chip select, read data, done/status, last
//   cfg      in   cfg_we_i only      cfg_idx_i, cfg_data_i
//
// A request is taken whenever the job queue has room, and the front
// end finishes its phase update in the cycle that takes it.
// Results leave at one per cycle while the sink is ready: a command frame is 8
// results, a retry 9, anything else 1; the back end's beat counter counts them.
// A stalled result sink holds the back end only; the front keeps taking
// requests until QueueDepth jobs are waiting.
// Reset returns the phase to idle and the limits to their defaults.
module sd_spi_block_transaction import sdspi_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  sdspi_in_if.sink    in_ch,
  sdspi_out_if.source out_ch
);

  logic push, pop, full, empty;
  job_t job_in, job_head;

  sdspi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  sdspi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_head)
  );

  sdspi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (job_head),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/sdspi_front.sv =====
// Front end: takes input requests, runs the transaction phase machine and
// posts one job per request that yields results. Uses sdspi_pkg, sdspi_if.
module sdspi_front import sdspi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  sdspi_in_if.sink    in_ch,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  op_kind_q, op_kind_d;
  logic [5:0]  cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;
  logic [11:0] xfer_len_q, xfer_len_d;
  logic [15:0] try_q, try_d;
  logic [15:0] byte_q, byte_d;
  logic [15:0] resp_lim_q, trans_lim_q;
  logic [11:0] block_len_q;
  logic        accept;
  logic [15:0] byte_inc, try_inc;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign byte_inc    = byte_q + 16'd1;
  assign try_inc     = try_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_lim_q  <= RESP_ATTEMPTS_RST;
      trans_lim_q <= TRANS_ATTEMPTS_RST;
      block_len_q <= BLOCK_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESP_ATTEMPTS:  resp_lim_q  <= cfg_data_i;
        CFG_TRANS_ATTEMPTS: trans_lim_q <= cfg_data_i;
        CFG_BLOCK_LEN:      block_len_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      op_kind_q  <= OP_BLK_RD;
      cmd_q      <= '0;
      arg_q      <= '0;
      xfer_len_q <= '0;
      try_q      <= '0;
      byte_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      op_kind_q  <= op_kind_d;
      cmd_q      <= cmd_d;
      arg_q      <= arg_d;
      xfer_len_q <= xfer_len_d;
      try_q      <= try_d;
      byte_q     <= byte_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    op_kind_d  = op_kind_q;
    cmd_d      = cmd_q;
    arg_d      = arg_q;
    xfer_len_d = xfer_len_q;
    try_d      = try_q;
    byte_d     = byte_q;
    push_o     = 1'b0;
    job_o      = '0;
    job_o.kind = JOB_SINGLE;
    job_o.cmd  = cmd_q;
    job_o.arg  = arg_q;

    if (accept) begin
      case (in_ch.func)
        FUNC_START: begin
          if (phase_q == PH_IDLE && in_ch.op != OP_NONE) begin
            op_kind_d  = in_ch.op;
            case (in_ch.op)
              OP_BLK_RD: cmd_d = CMD_READ_BLOCK;
              OP_BLK_WR: cmd_d = CMD_WRITE_BLOCK;
              default:   cmd_d = in_ch.cmd_index;
            endcase
            arg_d      = in_ch.argument;
            xfer_len_d = (in_ch.op == OP_REG_RD) ? in_ch.reg_len : block_len_q;
            try_d      = '0;
            byte_d     = '0;
            phase_d    = PH_R1;
            push_o     = 1'b1;
            job_o.kind = JOB_FRAME;
            job_o.cmd  = cmd_d;
            job_o.arg  = arg_d;
          end
        end
        FUNC_RX: begin
          case (phase_q)
            PH_R1: begin
              if (!in_ch.rx_byte[7]) begin
                byte_d = '0;
                if (in_ch.rx_byte != 8'd0) begin
                  phase_d        = PH_IDLE;
                  push_o         = 1'b1;
                  job_o.done_res = 1'b1;
                  job_o.status   = ST_BAD_R1;
                end else if (op_kind_q == OP_BLK_WR) begin
                  phase_d         = (xfer_len_q == 12'd0) ? PH_DRESP : PH_WDATA;
                  push_o          = 1'b1;
                  job_o.tx_valid  = 1'b1;
                  job_o.tx_byte   = TOKEN_START;
                  job_o.cs_active = 1'b1;
                end else begin
                  phase_d = PH_TOKEN;
                end
              end else if (reached(byte_inc, resp_lim_q)) begin
                byte_d = '0;
                try_d  = try_inc;
                push_o = 1'b1;
                if (reached(try_inc, trans_lim_q)) begin
                  phase_d        = PH_IDLE;
                  job_o.done_res = 1'b1;
                  job_o.status   = ST_BAD_R1;
                end else begin
                  job_o.kind = JOB_RETRY;
                end
              end else begin
                byte_d = byte_inc;
              end
            end
            PH_TOKEN: begin
              if (in_ch.rx_byte == TOKEN_START) begin
                byte_d  = '0;
                phase_d = (xfer_len_q == 12'd0) ? PH_CRC : PH_RDATA;
              end else if (in_ch.rx_byte != 8'd0 && in_ch.rx_byte <= ERR_TOKEN_MAX) begin
                phase_d        = PH_IDLE;
                push_o         = 1'b1;
                job_o.done_res = 1'b1;
                job_o.status   = ST_ERR_TOK;
              end else begin
                byte_d = byte_inc;
                if (reached(byte_inc, trans_lim_q)) begin
                  phase_d        = PH_IDLE;
                  push_o         = 1'b1;
                  job_o.done_res = 1'b1;
                  job_o.status   = ST_NO_TOKEN;
                end
              end
            end
            PH_RDATA: begin
              push_o           = 1'b1;
              job_o.cs_active  = 1'b1;
              job_o.data_valid = 1'b1;
              job_o.data_byte  = in_ch.rx_byte;
              byte_d           = byte_inc;
              if (byte_inc >= {4'd0, xfer_len_q}) begin
                byte_d  = '0;
                phase_d = PH_CRC;
              end
            end
            PH_CRC: begin
              byte_d = byte_inc;
              if (byte_inc >= CRC_BYTES) begin
                phase_d        = PH_IDLE;
                push_o         = 1'b1;
                job_o.done_res = 1'b1;
                job_o.status   = ST_OK;
              end
            end
            PH_DRESP: begin
              if ((in_ch.rx_byte & DRESP_MASK) == DRESP_MARK) begin
                phase_d        = PH_IDLE;
                push_o         = 1'b1;
                job_o.done_res = 1'b1;
                job_o.status   = (in_ch.rx_byte[3:1] == DRESP_ACCEPTED) ? ST_OK : ST_WR_REJ;
              end else begin
                byte_d = byte_inc;
                if (reached(byte_inc, trans_lim_q)) begin
                  phase_d        = PH_IDLE;
                  push_o         = 1'b1;
                  job_o.done_res = 1'b1;
                  job_o.status   = ST_NO_DRESP;
                end
              end
            end
            default: ;
          endcase
        end
        FUNC_WR: begin
          if (phase_q == PH_WDATA) begin
            push_o          = 1'b1;
            job_o.tx_valid  = 1'b1;
            job_o.tx_byte   = in_ch.wr_byte;
            job_o.cs_active = 1'b1;
            byte_d          = byte_inc;
            if (byte_inc >= {4'd0, xfer_len_q}) begin
              byte_d  = '0;
              phase_d = PH_DRESP;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // a frame or retry job always leaves the machine waiting for R1
  a_frame_r1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o.kind != JOB_SINGLE) |=> phase_q == PH_R1)
    else $error("frame job without R1 wait");

  // a done result returns the machine to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o.done_res) |=> phase_q == PH_IDLE)
    else $error("done job while busy");

  // nothing is posted while the queue is full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o)
    else $error("push into full queue");

endmodule

// ===== rtl/sdspi_queue.sv =====
// Short job queue between front and back end of the SD SPI sequencer.
// Register file with read and write pointers. Uses sdspi_pkg.
module sdspi_queue import sdspi_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntFull;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count overflow");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop of empty queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && push_i) |=> (!empty_o && job_o == $past(job_i)))
    else $error("pushed job not at head");

endmodule

// ===== rtl/sdspi_back.sv =====
// Back end: expands the job at the queue head into result requests,
// one per cycle while the sink is ready. Uses sdspi_pkg, sdspi_if.
module sdspi_back import sdspi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       job_i,
  output logic       pop_o,
  sdspi_out_if.source out_ch
);

  localparam logic [BEAT_W-1:0] FrameLast = BEAT_W'(FRAME_LEN - 1);
  localparam logic [BEAT_W-1:0] RetryLast = BEAT_W'(RETRY_LEN - 1);

  logic [BEAT_W-1:0] beat_q, beat_d;
  logic [BEAT_W-1:0] beat_last, frame_beat;
  logic              fire, is_last;

  always_comb begin
    case (job_i.kind)
      JOB_FRAME: beat_last = FrameLast;
      JOB_RETRY: beat_last = RetryLast;
      default:   beat_last = '0;
    endcase
  end

  assign is_last    = beat_q == beat_last;
  assign fire       = out_ch.valid && out_ch.ready;
  assign pop_o      = fire && is_last;
  assign beat_d     = pop_o ? '0 : beat_q + 1'b1;
  // retry shifts the frame one request back behind the chip select release
  assign frame_beat = (job_i.kind == JOB_RETRY) ? beat_q - 1'b1 : beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (fire) begin
      beat_q <= beat_d;
    end
  end

  always_comb begin
    out_ch.valid      = !empty_i;
    out_ch.last       = is_last;
    out_ch.tx_valid   = job_i.tx_valid;
    out_ch.tx_byte    = job_i.tx_byte;
    out_ch.cs_active  = job_i.cs_active;
    out_ch.data_valid = job_i.data_valid;
    out_ch.data_byte  = job_i.data_byte;
    out_ch.done_res   = job_i.done_res;
    out_ch.status     = job_i.status;
    if (job_i.kind != JOB_SINGLE) begin
      out_ch.data_valid = 1'b0;
      out_ch.data_byte  = '0;
      out_ch.done_res   = 1'b0;
      out_ch.status     = ST_OK;
      if (job_i.kind == JOB_RETRY && beat_q == '0) begin
        out_ch.tx_valid  = 1'b0;
        out_ch.tx_byte   = '0;
        out_ch.cs_active = 1'b0;
      end else begin
        out_ch.tx_valid  = 1'b1;
        out_ch.tx_byte   = frame_byte(frame_beat[2:0], job_i.cmd, job_i.arg);
        out_ch.cs_active = 1'b1;
      end
    end
  end

  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> beat_q <= beat_last)
    else $error("beat past end of job");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.done_res) |-> out_ch.last)
    else $error("done result not last");

  a_beat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(beat_q))
    else $error("beat moved without handshake");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the SD-card SPI-mode block transaction sequencer.
// Drives requests and checks the results against a cycle-free behavioural copy of the sequencer.
// Depends on sdspi_pkg, sdspi_if and sd_spi_block_transaction.
`timescale 1ns / 1ps

module tb_top;
  import sdspi_pkg::*;

  localparam logic [1:0] FUNC_IGNORED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  op;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [11:0] reg_len;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } sd_req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [2:0] status;
    logic       last;
  } sd_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_RESP_ATTEMPTS;
  logic [15:0] cfg_data = 16'd0;
  logic        req_valid = 1'b0;
  sd_req_t     req_drv = '0;
  logic        res_ready = 1'b0;

  // sequencer copy
  logic [15:0] resp_lim = RESP_ATTEMPTS_RST;
  logic [15:0] trans_lim = TRANS_ATTEMPTS_RST;
  logic [11:0] blk_len = BLOCK_LEN_RST;
  phase_e      card_phase = PH_IDLE;
  logic [1:0]  cur_op = OP_BLK_RD;
  logic [5:0]  cur_cmd = 6'd0;
  logic [31:0] cur_arg = 32'd0;
  logic [11:0] cur_len = 12'd0;
  logic [15:0] tries = 16'd0;
  logic [15:0] nbytes = 16'd0;

  sd_req_t spi_reqs_q[$];
  sd_res_t step_res[$];
  sd_res_t host_events_q[$];

  bit          calm = 1'b0;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int          errors = 0;

  sdspi_in_if  spi_req_if ();
  sdspi_out_if host_res_if ();

  assign spi_req_if.valid     = req_valid;
  assign spi_req_if.func      = req_drv.func;
  assign spi_req_if.op        = req_drv.op;
  assign spi_req_if.cmd_index = req_drv.cmd_index;
  assign spi_req_if.argument  = req_drv.argument;
  assign spi_req_if.reg_len   = req_drv.reg_len;
  assign spi_req_if.rx_byte   = req_drv.rx_byte;
  assign spi_req_if.wr_byte   = req_drv.wr_byte;
  assign host_res_if.ready    = res_ready;

  sd_spi_block_transaction DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (spi_req_if),
    .out_ch     (host_res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit limit_hit(logic [15:0] cnt, logic [15:0] lim);
    return cnt >= ((lim == 16'd0) ? 16'd1 : lim);
  endfunction

  task automatic add_res(logic txv, logic [7:0] txb, logic cs, logic dv, logic [7:0] db,
                         logic dn, logic [2:0] st);
    sd_res_t x;
    x.tx_valid   = txv;
    x.tx_byte    = txb;
    x.cs_active  = cs;
    x.data_valid = dv;
    x.data_byte  = db;
    x.done_res   = dn;
    x.status     = st;
    x.last       = 1'b0;
    step_res.push_back(x);
  endtask

  task automatic add_frame();
    add_res(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
    add_res(1'b1, BYTE_CMD_BASE | {2'b00, cur_cmd}, 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
    add_res(1'b1, cur_arg[31:24], 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
    add_res(1'b1, cur_arg[23:16], 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
    add_res(1'b1, cur_arg[15:8], 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
    add_res(1'b1, cur_arg[7:0], 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
    add_res(1'b1, BYTE_CRC, 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
    add_res(1'b1, BYTE_IDLE, 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
  endtask

  task automatic end_txn(logic [2:0] st);
    card_phase = PH_IDLE;
    add_res(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b1, st);
  endtask

  task automatic step_sequencer(sd_req_t r);
    sd_res_t x;
    step_res.delete();
    case (r.func)
      FUNC_START: begin
        if (card_phase == PH_IDLE && r.op != OP_NONE) begin
          cur_op  = r.op;
          cur_cmd = (r.op == OP_BLK_RD) ? CMD_READ_BLOCK :
                    (r.op == OP_BLK_WR) ? CMD_WRITE_BLOCK : r.cmd_index;
          cur_arg = r.argument;
          cur_len = (r.op == OP_REG_RD) ? r.reg_len : blk_len;
          tries   = 16'd0;
          nbytes  = 16'd0;
          card_phase = PH_R1;
          add_frame();
        end
      end
      FUNC_RX: begin
        case (card_phase)
          PH_R1: begin
            if (!r.rx_byte[7]) begin
              nbytes = 16'd0;
              if (r.rx_byte != 8'd0) begin
                end_txn(ST_BAD_R1);
              end else if (cur_op == OP_BLK_WR) begin
                add_res(1'b1, TOKEN_START, 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
                card_phase = (cur_len == 12'd0) ? PH_DRESP : PH_WDATA;
              end else begin
                card_phase = PH_TOKEN;
              end
            end else begin
              nbytes = nbytes + 16'd1;
              if (limit_hit(nbytes, resp_lim)) begin
                nbytes = 16'd0;
                tries  = tries + 16'd1;
                if (limit_hit(tries, trans_lim)) begin
                  end_txn(ST_BAD_R1);
                end else begin
                  // chip select dropped, then the command goes out again
                  add_res(1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, ST_OK);
                  add_frame();
                end
              end
            end
          end
          PH_TOKEN: begin
            if (r.rx_byte == TOKEN_START) begin
              nbytes = 16'd0;
              card_phase = (cur_len == 12'd0) ? PH_CRC : PH_RDATA;
            end else if (r.rx_byte != 8'd0 && r.rx_byte <= ERR_TOKEN_MAX) begin
              end_txn(ST_ERR_TOK);
            end else begin
              nbytes = nbytes + 16'd1;
              if (limit_hit(nbytes, trans_lim)) end_txn(ST_NO_TOKEN);
            end
          end
          PH_RDATA: begin
            add_res(1'b0, 8'd0, 1'b1, 1'b1, r.rx_byte, 1'b0, ST_OK);
            nbytes = nbytes + 16'd1;
            if (nbytes >= cur_len) begin
              nbytes = 16'd0;
              card_phase = PH_CRC;
            end
          end
          PH_CRC: begin
            nbytes = nbytes + 16'd1;
            if (nbytes >= CRC_BYTES) end_txn(ST_OK);
          end
          PH_DRESP: begin
            if ((r.rx_byte & DRESP_MASK) == DRESP_MARK) begin
              end_txn((r.rx_byte[3:1] == DRESP_ACCEPTED) ? ST_OK : ST_WR_REJ);
            end else begin
              nbytes = nbytes + 16'd1;
              if (limit_hit(nbytes, trans_lim)) end_txn(ST_NO_DRESP);
            end
          end
          default: ;
        endcase
      end
      FUNC_WR: begin
        if (card_phase == PH_WDATA) begin
          add_res(1'b1, r.wr_byte, 1'b1, 1'b0, 8'd0, 1'b0, ST_OK);
          nbytes = nbytes + 16'd1;
          if (nbytes >= cur_len) begin
            nbytes = 16'd0;
            card_phase = PH_DRESP;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < step_res.size(); i++) begin
      x = step_res[i];
      x.last = (i == step_res.size() - 1);
      host_events_q.push_back(x);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic sd_req_t rand_req(logic [1:0] f);
    sd_req_t r;
    r.func      = f;
    r.op        = 2'($urandom);
    r.cmd_index = 6'($urandom);
    r.argument  = $urandom;
    r.reg_len   = 12'($urandom);
    r.rx_byte   = 8'($urandom);
    r.wr_byte   = 8'($urandom);
    return r;
  endfunction

  task automatic push_start(logic [1:0] op, logic [5:0] cmd, logic [31:0] arg,
                            logic [11:0] len);
    sd_req_t r;
    r = rand_req(FUNC_START);
    r.op        = op;
    r.cmd_index = cmd;
    r.argument  = arg;
    r.reg_len   = len;
    spi_reqs_q.push_back(r);
  endtask

  task automatic push_rx(logic [7:0] b);
    sd_req_t r;
    r = rand_req(FUNC_RX);
    r.rx_byte = b;
    spi_reqs_q.push_back(r);
  endtask

  task automatic push_wr(logic [7:0] b);
    sd_req_t r;
    r = rand_req(FUNC_WR);
    r.wr_byte = b;
    spi_reqs_q.push_back(r);
  endtask

  // One transaction with random content; a non-negative op_pick picks the operation, a negative one a random one.
  task automatic queue_txn(bit allow_fail, int op_pick, output int n);
    longint     limit;
    int         resp_eff, trans_eff, k, j, len, n0, noise;
    logic [1:0] op;
    logic [7:0] b;
    logic [2:0] code;
    n0 = spi_reqs_q.size();
    noise = 0;
    resp_eff  = (resp_lim == 16'd0) ? 1 : int'(resp_lim);
    trans_eff = (trans_lim == 16'd0) ? 1 : int'(trans_lim);

    // stray requests while idle
    if ($urandom_range(9) == 0) begin
      push_rx(8'($urandom));
      noise++;
    end
    if ($urandom_range(11) == 0) begin
      push_wr(8'($urandom));
      noise++;
    end
    if ($urandom_range(13) == 0) begin
      push_start(OP_NONE, 6'($urandom), $urandom, 12'($urandom));
      noise++;
    end
    if ($urandom_range(13) == 0) begin
      spi_reqs_q.push_back(rand_req(FUNC_IGNORED));
      noise++;
    end

    op = (op_pick < 0) ? 2'($urandom_range(2)) : 2'(op_pick);
    if (op == OP_REG_RD) begin
      len = ($urandom_range(6) == 0) ? 0 : $urandom_range(1, 6);
      push_start(op, 6'($urandom), $urandom, 12'(len));
    end else begin
      len = int'(blk_len);
      push_start(op, 6'($urandom), $urandom, 12'($urandom));
    end
    if ($urandom_range(7) == 0) begin
      push_start(2'($urandom), 6'($urandom), $urandom, 12'($urandom));
      noise++;
    end

    // busy bytes ahead of R1; enough of them exhausts every try
    limit = longint'(resp_eff) * trans_eff;
    if (allow_fail && limit <= 24 && $urandom_range(7) == 0)
      k = int'(limit);
    else
      k = $urandom_range(0, int'((limit > 12) ? 12 : limit - 1));
    for (int i = 0; i < k; i++) push_rx(8'($urandom) | 8'h80);
    if (allow_fail && $urandom_range(9) == 0)
      push_rx(8'($urandom_range(1, 127)));
    else
      push_rx(8'h00);

    if (allow_fail && trans_eff <= 12 && $urandom_range(7) == 0)
      j = trans_eff;
    else
      j = $urandom_range(0, (trans_eff > 3) ? 3 : trans_eff - 1);

    if (op == OP_BLK_WR) begin
      for (int i = 0; i < len; i++) begin
        push_wr(8'($urandom));
        if ($urandom_range(15) == 0) begin
          push_rx(8'($urandom));
          noise++;
        end
      end
      for (int i = 0; i < j; i++) begin
        do b = 8'($urandom); while ((b & DRESP_MASK) == DRESP_MARK);
        push_rx(b);
      end
      code = (allow_fail && $urandom_range(4) == 0) ? 3'($urandom) : DRESP_ACCEPTED;
      push_rx({3'($urandom), 1'b0, code, 1'b1});
    end else begin
      for (int i = 0; i < j; i++) begin
        do b = 8'($urandom);
        while (b == TOKEN_START || (b != 8'd0 && b <= ERR_TOKEN_MAX));
        push_rx(b);
      end
      if (allow_fail && $urandom_range(9) == 0)
        push_rx(8'($urandom_range(1, 8)));
      else
        push_rx(TOKEN_START);
      for (int i = 0; i < len; i++) push_rx(8'($urandom));
      push_rx(8'($urandom));
      push_rx(8'($urandom));
    end
    n = spi_reqs_q.size() - n0 - noise;
  endtask

  task automatic fill(int target);
    int got, n;
    got = 0;
    while (got < target) begin
      queue_txn(1'b1, -1, n);
      got += n;
    end
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_RESP_ATTEMPTS:  resp_lim = val;
      CFG_TRANS_ATTEMPTS: trans_lim = val;
      default:            blk_len = val[11:0];
    endcase
  endtask

  task automatic configure(logic [15:0] resp, logic [15:0] trans, logic [11:0] blk);
    write_cfg(CFG_RESP_ATTEMPTS, resp);
    write_cfg(CFG_TRANS_ATTEMPTS, trans);
    write_cfg(CFG_BLOCK_LEN, {4'd0, blk});
  endtask

  // everything accepted and answered, then a pause for requests that leave nothing behind
  task automatic settle();
    while (spi_reqs_q.size() != 0 || req_valid || host_events_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(16'd2, 16'd3, 12'd2);
    spi_reqs_q.push_back(rand_req(FUNC_IGNORED));
    push_rx(8'hFF);
    push_wr(8'h00);
    push_start(OP_NONE, 6'd5, 32'h1234_5678, 12'd7);
    push_start(OP_BLK_RD, 6'd0, 32'hFFFF_FFFF, 12'hFFF);
    push_rx(8'hFF);
    push_rx(8'h80);                                   // second busy byte: retry
    push_start(OP_REG_RD, 6'd63, 32'd0, 12'd1);       // busy, dropped
    push_rx(8'h00);
    push_rx(TOKEN_START);
    push_rx(8'hA5);
    push_rx(8'h5A);
    push_rx(8'h00);
    push_rx(8'hFF);
    push_start(OP_BLK_WR, 6'd63, 32'd0, 12'd0);
    push_rx(8'h00);
    push_wr(8'hFF);
    push_rx(8'h33);                                   // not awaited while sending
    push_wr(8'h00);
    push_rx(8'h05);
    push_start(OP_REG_RD, 6'd63, 32'h8000_0001, 12'd1);
    push_rx(8'h7F);
    settle();

    configure(16'd3, 16'd2, 12'd5);
    hold_arm <= 1'b1;
    fill(60);
    settle();

    configure(16'd0, 16'd0, 12'd1);
    calm <= 1'b1;
    fill(40);
    settle();
    calm <= 1'b0;

    configure(16'hFFFF, 16'hFFFF, 12'd0);
    fill(40);
    settle();

    configure(16'd1, 16'd1, 12'd3);
    fill(40);
    settle();

    configure(16'd4, 16'd6, 12'd7);
    fill(40);
    settle();

    // one clean block each way at the default retry limits
    configure(16'd8, 16'd1000, 12'd8);
    queue_txn(1'b0, OP_BLK_RD, n);
    queue_txn(1'b0, OP_BLK_WR, n);
    settle();

    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin : driver
    bit take;
    if (rst_ni) begin
      take = req_valid && spi_req_if.ready;
      if (take) step_sequencer(req_drv);
      if (!req_valid || take) begin
        if (spi_reqs_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          req_drv   <= spi_reqs_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the job queue fills and the request side stalls
  always @(posedge clk_i) begin
    if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    sd_res_t want;
    if (rst_ni) begin
      if (host_res_if.valid && res_ready) begin
        if (host_events_q.size() == 0) begin
          $display("%0t: result with none outstanding, tx %0h/%0h data %0h/%0h done %0h st %0h",
                   $time, host_res_if.tx_valid, host_res_if.tx_byte, host_res_if.data_valid,
                   host_res_if.data_byte, host_res_if.done_res, host_res_if.status);
          errors++;
        end else begin
          want = host_events_q.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(host_res_if.tx_valid));
          check_field("tx_byte", want.tx_byte, host_res_if.tx_byte);
          check_field("cs_active", 8'(want.cs_active), 8'(host_res_if.cs_active));
          check_field("data_valid", 8'(want.data_valid), 8'(host_res_if.data_valid));
          check_field("data_byte", want.data_byte, host_res_if.data_byte);
          check_field("done_res", 8'(want.done_res), 8'(host_res_if.done_res));
          check_field("status", 8'(want.status), 8'(host_res_if.status));
          check_field("last", 8'(want.last), 8'(host_res_if.last));
        end
      end
      res_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/sdspi_pkg.sv
rtl/sdspi_if.sv
rtl/sdspi_front.sv
rtl/sdspi_queue.sv
rtl/sdspi_back.sv
rtl/sd_spi_block_transaction.sv
test/tb_top.sv
